>>> src/layer_priority_alpha_blend_top_defines.svh
// Assertion macros used by the checker file of the compositor.
`ifndef LAYER_PRIORITY_ALPHA_BLEND_TOP_DEFINES_SVH
`define LAYER_PRIORITY_ALPHA_BLEND_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define LPAB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("compositor check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define LPAB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("compositor check failed");

`endif

>>> src/lpab_pkg.sv
// Types and constants of the layer priority and alpha blend compositor.
`default_nettype none
package lpab_pkg;

	localparam int unsigned COLOR_W = 15;
	localparam int unsigned RANK_W = 8;
	localparam int unsigned LAYER_W = 3;
	localparam int unsigned RGB_W = 24;
	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 24;
	localparam int unsigned M_TUSER_W = 1;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 15;

	localparam logic [RANK_W-1:0] BACKDROP_RANK = 8'd255;
	localparam logic [LAYER_W-1:0] BACKDROP_LAYER = 3'd5;
	localparam logic [4:0] COEF_MAX = 5'd16;
	localparam logic [7:0] CHAN_MAX = 8'd255;
	localparam logic [1:0] MODE_ALPHA = 2'd1;

	localparam logic [CFG_INDEX_W-1:0] REG_BLEND_CONTROL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_COEF = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKDROP_COLOR = 2'd2;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [RANK_W-1:0] rank;
		logic [LAYER_W-1:0] layer;
		logic semi;
		logic backdrop;
	} sample_t;

	localparam sample_t BACKDROP_SAMPLE = '{
		color: '0,
		rank: BACKDROP_RANK,
		layer: BACKDROP_LAYER,
		semi: 1'b0,
		backdrop: 1'b1
	};

endpackage
`default_nettype wire

>>> src/layer_priority_alpha_blend_top.sv
// Top level of the per-pixel layer priority and alpha blend compositor.
//
// Layer samples of one pixel arrive on the s_axis group, one request each.
// s_tdata carries the color, rank and layer, s_tuser the present and
// semi-transparent flags, and s_tlast marks the last sample of the pixel.
// Each request on the sample channel is taken while s_tready is high. On the
// last sample the two best samples by rank move into a register stage, and
// from there the blended RGB888 pixel moves into the output register on the
// m_axis group once that register is free, with m_tuser high when alpha
// blending was applied.
// Registers are written over the cfg channel, which is always ready; they
// should be changed only while no pixel is in flight.
// Reset clears both sample slots to the backdrop, empties both register
// stages and clears all three registers.
// When the receiver stalls, one resolved pixel waits in the output register
// and one more in the stage before it; once both hold a pixel, s_tready
// stays low until the receiver takes one.
`default_nettype none
module layer_priority_alpha_blend_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// [14:0] layer_color, [22:15] priority_rank, [25:23] layer_id, rest zero
	input  wire logic [lpab_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] present, [1] semi_transparent
	input  wire logic [lpab_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic s_tlast,
	output logic m_tvalid,
	input  wire logic m_tready,
	// [23:0] pixel_rgb, red in the low byte
	output logic [lpab_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] blended
	output logic [lpab_pkg::M_TUSER_W-1:0] m_tuser,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [lpab_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lpab_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lpab_pkg::*;

	logic [13:0] blend_control_q;
	logic [12:0] alpha_coef_q;
	logic [COLOR_W-1:0] backdrop_color_q;

	sample_t front_q, behind_q;
	sample_t front_nxt, behind_nxt;
	sample_t in_sample;
	sample_t front_s1, behind_s1;
	logic valid_s1;

	logic out_adv, s1_free, s_accept;
	logic [RGB_W-1:0] rgb_nxt;
	logic mixed_nxt;
	logic [RGB_W-1:0] rgb_q;
	logic mixed_q;
	logic valid_q;

	function automatic logic [RGB_W-1:0] widen555(input logic [COLOR_W-1:0] c);
		return {c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
	endfunction

	function automatic logic [4:0] clamp_coef(input logic [4:0] v);
		return (v > COEF_MAX) ? COEF_MAX : v;
	endfunction

	function automatic logic [7:0] mix_chan(input logic [7:0] t, input logic [7:0] l,
		input logic [4:0] eva, input logic [4:0] evb);
		logic [13:0] sum;
		logic [9:0] v;
		sum = 14'(t * eva) + 14'(l * evb);
		v = sum[13:4];
		return (v > 10'(CHAN_MAX)) ? CHAN_MAX : v[7:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_control_q <= '0;
			alpha_coef_q <= '0;
			backdrop_color_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BLEND_CONTROL: blend_control_q <= cfg_data[13:0];
				REG_ALPHA_COEF: alpha_coef_q <= cfg_data[12:0];
				REG_BACKDROP_COLOR: backdrop_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_adv = !valid_q || m_tready;
	assign s1_free = !valid_s1 || out_adv;
	assign s_tready = s1_free;
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		in_sample.color = s_tdata[14:0];
		in_sample.rank = s_tdata[22:15];
		in_sample.layer = s_tdata[25:23];
		in_sample.semi = s_tuser[1];
		in_sample.backdrop = 1'b0;
		front_nxt = front_q;
		behind_nxt = behind_q;
		if (s_tuser[0]) begin
			priority if (in_sample.rank < front_q.rank) begin
				behind_nxt = front_q;
				front_nxt = in_sample;
			end else if (in_sample.rank < behind_q.rank) begin
				behind_nxt = in_sample;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= BACKDROP_SAMPLE;
			behind_q <= BACKDROP_SAMPLE;
			valid_s1 <= 1'b0;
		end else begin
			if (s_accept) begin
				if (s_tlast) begin
					front_q <= BACKDROP_SAMPLE;
					behind_q <= BACKDROP_SAMPLE;
				end else begin
					front_q <= front_nxt;
					behind_q <= behind_nxt;
				end
			end
			if (s1_free) begin
				valid_s1 <= s_accept && s_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && s_tlast) begin
			front_s1 <= front_nxt;
			behind_s1 <= behind_nxt;
		end
	end

	always_comb begin
		logic [RGB_W-1:0] top_rgb, low_rgb;
		logic [4:0] eva, evb;
		logic first_tgt, second_tgt, mode_alpha;
		top_rgb = widen555(front_s1.backdrop ? backdrop_color_q : front_s1.color);
		low_rgb = widen555(behind_s1.backdrop ? backdrop_color_q : behind_s1.color);
		eva = clamp_coef(alpha_coef_q[4:0]);
		evb = clamp_coef(alpha_coef_q[12:8]);
		first_tgt = (front_s1.layer < 3'd6) && blend_control_q[front_s1.layer];
		second_tgt = (behind_s1.layer < 3'd6) && blend_control_q[4'd8 + 4'(behind_s1.layer)];
		mode_alpha = (blend_control_q[7:6] == MODE_ALPHA) && first_tgt;
		mixed_nxt = (front_s1.semi || mode_alpha) && second_tgt;
		if (mixed_nxt) begin
			rgb_nxt = {mix_chan(top_rgb[23:16], low_rgb[23:16], eva, evb),
				mix_chan(top_rgb[15:8], low_rgb[15:8], eva, evb),
				mix_chan(top_rgb[7:0], low_rgb[7:0], eva, evb)};
		end else begin
			rgb_nxt = top_rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_adv) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			rgb_q <= rgb_nxt;
			mixed_q <= mixed_nxt;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = rgb_q;
	assign m_tuser = mixed_q;

endmodule
`default_nettype wire

>>> src/lpab_checker.sv
// Port-level checker of the compositor and its bind to the top level.
`default_nettype none
`include "layer_priority_alpha_blend_top_defines.svh"
module lpab_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tready,
	input  wire logic m_tvalid,
	input  wire logic m_tready,
	input  wire logic [lpab_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic [lpab_pkg::M_TUSER_W-1:0] m_tuser
);
	import lpab_pkg::*;

	// A pixel that is not blended shows each channel widened by bit copy.
	`LPAB_ASSERT_NOW(a_widen_copy, m_tvalid && !m_tuser[0], (m_tdata[2:0] == m_tdata[7:5]) && (m_tdata[10:8] == m_tdata[15:13]) && (m_tdata[18:16] == m_tdata[23:21]))

	// The sample channel only backs up behind a stalled output.
	`LPAB_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)

	// A stalled result holds its value.
	`LPAB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind layer_priority_alpha_blend_top lpab_checker u_lpab_checker (.*);
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the layer priority and alpha blend compositor.
module testbench;
	import lpab_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1150;
	localparam int RECONFIG_EVERY = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [COLOR_W-1:0] color;
		logic [RANK_W-1:0] rank;
		logic [LAYER_W-1:0] layer;
		logic present;
		logic semi;
		logic last;
	} layer_item_t;

	typedef struct {
		logic [RGB_W-1:0] rgb;
		logic blended;
	} pixel_t;

	typedef enum {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		layer_item_t item;
		bit pinned;
		pixel_t pinned_pixel;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [13:0] blend_ctrl;
	logic [12:0] alpha_coef;
	logic [14:0] backdrop_rgb555;
	sample_t front_slot;
	sample_t behind_slot;

	pixel_t awaited_pixels[$];
	pixel_t head_pixel;
	script_row_t directed_rows[$];
	int error_count = 0;
	int stall_cycles = 0;
	bit quiet = 1'b0;

	layer_priority_alpha_blend_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [RGB_W-1:0] widen_rgb555(input logic [14:0] c);
		return {c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
	endfunction

	function automatic int unsigned clamp_weight(input logic [4:0] w);
		return 32'((w > COEF_MAX) ? COEF_MAX : w);
	endfunction

	function automatic logic [14:0] slot_color(input sample_t s);
		return s.backdrop ? backdrop_rgb555 : s.color;
	endfunction

	// Orders one layer sample into the two slots and resolves the pixel on the last one.
	function automatic bit composite_sample(input layer_item_t it, output pixel_t px);
		sample_t s;
		logic [RGB_W-1:0] top;
		logic [RGB_W-1:0] low;
		bit mode_alpha;
		bit mixed;
		int unsigned eva;
		int unsigned evb;
		int unsigned v;
		px.rgb = '0;
		px.blended = 1'b0;
		if (it.present) begin
			s.color = it.color;
			s.rank = it.rank;
			s.layer = it.layer;
			s.semi = it.semi;
			s.backdrop = 1'b0;
			if (s.rank < front_slot.rank) begin
				behind_slot = front_slot;
				front_slot = s;
			end else if (s.rank < behind_slot.rank) begin
				behind_slot = s;
			end
		end
		if (!it.last)
			return 1'b0;
		top = widen_rgb555(slot_color(front_slot));
		mode_alpha = blend_ctrl[7:6] == MODE_ALPHA && front_slot.layer < 6
			&& blend_ctrl[front_slot.layer];
		mixed = (front_slot.semi || mode_alpha) && behind_slot.layer < 6
			&& blend_ctrl[8 + behind_slot.layer];
		px.rgb = top;
		if (mixed) begin
			low = widen_rgb555(slot_color(behind_slot));
			eva = clamp_weight(alpha_coef[4:0]);
			evb = clamp_weight(alpha_coef[12:8]);
			for (int ch = 0; ch < 3; ch++) begin
				v = (top[8*ch +: 8] * eva + low[8*ch +: 8] * evb) >> 4;
				px.rgb[8*ch +: 8] = (v > CHAN_MAX) ? CHAN_MAX : v[7:0];
			end
		end
		px.blended = mixed;
		front_slot = BACKDROP_SAMPLE;
		behind_slot = BACKDROP_SAMPLE;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic send_layer(input layer_item_t it, input bit pinned, input pixel_t pin);
		pixel_t px;
		if (!quiet && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 9);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - 26){1'b0}}, it.layer, it.rank, it.color};
		s_tuser <= {it.semi, it.present};
		s_tlast <= it.last;
		do @(posedge clk); while (!s_tready);
		if (composite_sample(it, px))
			awaited_pixels.push_back(pinned ? pin : px);
	endtask

	// Registers change only with no pixel in flight.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		s_tvalid <= 1'b0;
		while (awaited_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BLEND_CONTROL: blend_ctrl = value[13:0];
			REG_ALPHA_COEF: alpha_coef = value[12:0];
			REG_BACKDROP_COLOR: backdrop_rgb555 = value;
			default: ;
		endcase
	endtask

	function automatic script_row_t sample_row(input logic [14:0] color,
			input logic [7:0] rank, input logic [2:0] layer, input bit present,
			input bit semi, input bit last);
		script_row_t r;
		r.kind = ROW_SAMPLE;
		r.reg_index = '0;
		r.reg_value = '0;
		r.item.color = color;
		r.item.rank = rank;
		r.item.layer = layer;
		r.item.present = present;
		r.item.semi = semi;
		r.item.last = last;
		r.pinned = 1'b0;
		r.pinned_pixel.rgb = '0;
		r.pinned_pixel.blended = 1'b0;
		return r;
	endfunction

	function automatic script_row_t pinned_row(input script_row_t r,
			input logic [23:0] rgb, input bit blended);
		r.pinned = 1'b1;
		r.pinned_pixel.rgb = rgb;
		r.pinned_pixel.blended = blended;
		return r;
	endfunction

	function automatic script_row_t config_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		script_row_t r;
		r = sample_row('0, '0, '0, 1'b0, 1'b0, 1'b0);
		r.kind = ROW_CONFIG;
		r.reg_index = idx;
		r.reg_value = value;
		return r;
	endfunction

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= 9);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel %06h with none awaited", m_tdata));
			end else begin
				head_pixel = awaited_pixels.pop_front();
				if (m_tdata !== head_pixel.rgb)
					report_mismatch($sformatf("pixel_rgb %06h, awaited %06h",
						m_tdata, head_pixel.rgb));
				if (m_tuser[0] !== head_pixel.blended)
					report_mismatch($sformatf("blended %b, awaited %b",
						m_tuser[0], head_pixel.blended));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		layer_item_t it;
		pixel_t no_pin;
		int items_sent;
		int next_reconfig;
		int phase;
		int count;
		bit noise;
		logic [7:0] shared_rank;
		logic [14:0] blend_value;

		blend_ctrl = '0;
		alpha_coef = '0;
		backdrop_rgb555 = '0;
		front_slot = BACKDROP_SAMPLE;
		behind_slot = BACKDROP_SAMPLE;
		no_pin.rgb = '0;
		no_pin.blended = 1'b0;

		// Reset values: every register zero, so nothing blends and the backdrop is black.
		directed_rows.push_back(pinned_row(sample_row(15'h7FFF, 8'd0, 3'd0, 0, 1, 1),
			24'h000000, 0));
		directed_rows.push_back(pinned_row(sample_row(15'h7FFF, 8'd0, 3'd0, 1, 0, 1),
			24'hFFFFFF, 0));
		directed_rows.push_back(sample_row(15'h001F, 8'd10, 3'd1, 1, 0, 0));
		directed_rows.push_back(pinned_row(sample_row(15'h03E0, 8'd10, 3'd2, 1, 0, 1),
			24'h0000FF, 0));
		directed_rows.push_back(pinned_row(sample_row(15'h7FFF, 8'd255, 3'd3, 1, 1, 1),
			24'h000000, 0));
		directed_rows.push_back(sample_row(15'h7C00, 8'd7, 3'd6, 1, 1, 0));
		directed_rows.push_back(pinned_row(sample_row(15'h5555, 8'd7, 3'd7, 1, 0, 1),
			24'hFF0000, 0));
		directed_rows.push_back(config_row(REG_BLEND_CONTROL, 15'h3F7F));
		directed_rows.push_back(config_row(REG_ALPHA_COEF, 15'h1010));
		directed_rows.push_back(config_row(REG_BACKDROP_COLOR, 15'h7FFF));
		directed_rows.push_back(config_row(REG_UNUSED, 15'h7FFF));
		directed_rows.push_back(pinned_row(sample_row(15'h7FFF, 8'd1, 3'd0, 1, 1, 1),
			24'hFFFFFF, 1));
		directed_rows.push_back(sample_row(15'h4210, 8'd3, 3'd4, 1, 0, 0));
		directed_rows.push_back(sample_row(15'h0C63, 8'd5, 3'd2, 1, 1, 0));
		directed_rows.push_back(sample_row(15'h7FFF, 8'd0, 3'd6, 0, 0, 1));
		directed_rows.push_back(sample_row(15'h1234, 8'd2, 3'd6, 1, 0, 0));
		directed_rows.push_back(sample_row(15'h7FFF, 8'd9, 3'd1, 1, 0, 1));
		directed_rows.push_back(sample_row(15'h2AAA, 8'd4, 3'd3, 1, 1, 0));
		directed_rows.push_back(sample_row(15'h5555, 8'd8, 3'd7, 1, 0, 1));
		// A mode other than alpha, with both weights above the clamp.
		directed_rows.push_back(config_row(REG_BLEND_CONTROL, 15'h3FBF));
		directed_rows.push_back(config_row(REG_ALPHA_COEF, 15'h1F1F));
		directed_rows.push_back(config_row(REG_BACKDROP_COLOR, 15'h1234));
		directed_rows.push_back(sample_row(15'h6318, 8'd2, 3'd0, 1, 0, 1));
		directed_rows.push_back(sample_row(15'h6318, 8'd2, 3'd0, 1, 1, 1));
		directed_rows.push_back(config_row(REG_BLEND_CONTROL, 15'h2AC1));
		directed_rows.push_back(config_row(REG_ALPHA_COEF, 15'h0000));
		directed_rows.push_back(config_row(REG_BACKDROP_COLOR, 15'h0000));
		directed_rows.push_back(pinned_row(sample_row(15'h7FFF, 8'd0, 3'd0, 1, 1, 1),
			24'h000000, 1));
		directed_rows.push_back(pinned_row(sample_row(15'h7FFF, 8'd0, 3'd0, 1, 0, 1),
			24'hFFFFFF, 0));
		directed_rows.push_back(config_row(REG_BLEND_CONTROL, 15'h3F41));
		directed_rows.push_back(config_row(REG_ALPHA_COEF, 15'h0410));
		directed_rows.push_back(sample_row(15'h7FFF, 8'd0, 3'd0, 1, 0, 0));
		directed_rows.push_back(sample_row(15'h7FFF, 8'd1, 3'd1, 1, 0, 1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG)
				write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
			else
				send_layer(directed_rows[i].item, directed_rows[i].pinned,
					directed_rows[i].pinned_pixel);
		end

		items_sent = 0;
		next_reconfig = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= next_reconfig) begin
				if (phase == 0) begin
					write_register(REG_BLEND_CONTROL, 15'h7FFF);
					write_register(REG_ALPHA_COEF, 15'h7FFF);
					write_register(REG_BACKDROP_COLOR, 15'h7FFF);
				end else if (phase == 1) begin
					write_register(REG_BLEND_CONTROL, 15'h0000);
					write_register(REG_ALPHA_COEF, 15'h0000);
					write_register(REG_BACKDROP_COLOR, 15'h0000);
				end else begin
					blend_value = 15'($urandom_range(32767));
					if ($urandom_range(9) < 6)
						blend_value[7:6] = MODE_ALPHA;
					write_register(REG_BLEND_CONTROL, blend_value);
					write_register(REG_ALPHA_COEF, 15'($urandom_range(32767)));
					write_register(REG_BACKDROP_COLOR, 15'($urandom_range(32767)));
				end
				phase++;
				next_reconfig += RECONFIG_EVERY;
			end
			quiet = items_sent >= 500 && items_sent < 800;
			count = $urandom_range(6, 1);
			shared_rank = 8'($urandom_range(255));
			noise = $urandom_range(19) == 0;
			for (int k = 0; k < count; k++) begin
				it.color = 15'($urandom_range(32767));
				case ($urandom_range(9))
					0: it.rank = 8'd0;
					1: it.rank = 8'd255;
					2, 3: it.rank = shared_rank;
					default: it.rank = 8'($urandom_range(255));
				endcase
				it.layer = 3'(($urandom_range(9) == 0) ? $urandom_range(7, 6)
					: $urandom_range(5));
				it.present = noise ? ($urandom_range(3) == 0) : ($urandom_range(99) < 85);
				it.semi = $urandom_range(3) == 0;
				it.last = k == count - 1;
				send_layer(it, 1'b0, no_pin);
				items_sent++;
			end
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		while (awaited_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
